// ----- rtl/pirq_pkg.sv -----
// Package: shared constants, types and helpers of the PIR presence qualifier.
package pirq_pkg;

    localparam int unsigned HOLD_MS      = 5000;
    localparam int unsigned BURST_SPAN_S = 180;
    localparam int unsigned MS_PER_S     = 1000;
    localparam int unsigned S_PER_MIN    = 60;
    localparam int unsigned COUNT_MIN_EXTEND = 2;

    localparam logic [31:0] HOLD_LIMIT  = 32'(HOLD_MS);
    localparam logic [31:0] BURST_LIMIT = 32'(BURST_SPAN_S * MS_PER_S);
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
    localparam logic [15:0] COUNT_EXT   = 16'(COUNT_MIN_EXTEND);

    localparam logic [7:0]  WINDOW_RESET = 8'd5;
    localparam logic        NOTIFY_RESET = 1'b0;

    // Configuration register indexes
    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_NOTIFY = 1'b1;

    typedef struct packed {
        logic        pir_state;
        logic        sampled;
        logic        notify_valid;
        logic        notify_level;
        logic [15:0] presence_count;
        logic        burst_restarted;
    } t_result;

    // floor(d/1000) <= w*60 holds exactly when d < (w*60 + 1) * 1000.
    function automatic logic [31:0] window_limit(input logic [7:0] w);
        logic [31:0] prod;
        prod = 32'(w) * 32'(S_PER_MIN * MS_PER_S);
        return prod + 32'(MS_PER_S);
    endfunction

endpackage

// ----- rtl/pirq_in_if.sv -----
// Interface: input item channel (timestamp and sensor level).
interface pirq_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] time_ms;
    logic        pir_level;

    modport source (output valid, output time_ms, output pir_level, input ready);
    modport sink   (input valid, input time_ms, input pir_level, output ready);
endinterface

// ----- rtl/pirq_out_if.sv -----
// Interface: result item channel of the qualifier.
interface pirq_out_if;
    logic        valid;
    logic        ready;
    logic        pir_state;
    logic        sampled;
    logic        notify_valid;
    logic        notify_level;
    logic [15:0] presence_count;
    logic        burst_restarted;

    modport source (output valid, output pir_state, output sampled, output notify_valid,
                    output notify_level, output presence_count, output burst_restarted,
                    input ready);
    modport sink   (input valid, input pir_state, input sampled, input notify_valid,
                    input notify_level, input presence_count, input burst_restarted,
                    output ready);
endinterface

// ----- rtl/pirq_core.sv -----
// Core: qualification state, burst tracking and per-item result logic.
module pirq_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [31:0]      i_time_ms,
    input  logic             i_pir_level,
    input  logic [31:0]      i_win_limit,
    input  logic             i_notify_en,
    output pirq_pkg::t_result o_result
);
    import pirq_pkg::*;

    logic        r_motion, n_motion;
    logic [31:0] r_hold_start, n_hold_start;
    logic [31:0] r_first, n_first;
    logic [31:0] r_last, n_last;
    logic [15:0] r_count, n_count;

    logic [31:0] d_hold, d_first, d_last;
    logic        sample, extend;
    t_result     res;

    assign d_hold  = i_time_ms - r_hold_start;
    assign d_first = i_time_ms - r_first;
    assign d_last  = i_time_ms - r_last;
    assign sample  = (d_hold >= HOLD_LIMIT) || !r_motion;
    assign extend  = (d_first < BURST_LIMIT) || ((d_last < i_win_limit) && (r_count > COUNT_EXT));

    always_comb begin
        n_motion     = r_motion;
        n_hold_start = r_hold_start;
        n_first      = r_first;
        n_last       = r_last;
        n_count      = r_count;
        res          = '0;
        if (sample) begin
            res.sampled = 1'b1;
            if (i_notify_en && r_motion && !i_pir_level) begin
                res.notify_valid = 1'b1;
            end
            n_motion = i_pir_level;
            if (i_pir_level) begin
                n_hold_start = i_time_ms;
                if (i_notify_en) begin
                    res.notify_valid = 1'b1;
                    res.notify_level = 1'b1;
                end
                if (extend) begin
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + 16'd1;
                    end
                    n_last = i_time_ms;
                end else begin
                    n_first = i_time_ms;
                    n_last  = i_time_ms;
                    n_count = 16'd1;
                    res.burst_restarted = 1'b1;
                end
            end
        end
        res.pir_state      = n_motion;
        res.presence_count = n_count;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion     <= 1'b0;
            r_hold_start <= '0;
            r_first      <= '0;
            r_last       <= '0;
            r_count      <= '0;
        end else if (i_advance) begin
            r_motion     <= n_motion;
            r_hold_start <= n_hold_start;
            r_first      <= n_first;
            r_last       <= n_last;
            r_count      <= n_count;
        end
    end

endmodule

// ----- rtl/pir_presence_qualifier.sv -----
// Top level: PIR presence qualifier with input stage, core and result register.
//
//  channel   direction  payload                                         transfer
//  i_item    in         time_ms[31:0], pir_level                        valid & ready
//  o_result  out        pir_state, sampled, notify_valid, notify_level, valid & ready
//                       presence_count[15:0], burst_restarted
//  i_cfg_*   in         index 0 presence_window_min[7:0], 1 notify_enable  i_cfg_we
//
// One item per cycle sustained while the result side is ready; items pass the input
// register, then the core compares and burst counter update land in the result register.
// Reset (synchronous, active low) clears the qualification state, both valid flags
// and restores window 5 minutes, notifications off.
// A stalled result holds the pipe; the input register still takes a transfer
// whenever it is empty, so the block never waits on an idle neighbor.
module pir_presence_qualifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pirq_in_if.sink     i_item,
    pirq_out_if.source  o_result,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import pirq_pkg::*;

    // Configuration: keep the window as a precomputed millisecond bound.
    logic        r_notify_en;
    logic [31:0] r_win_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_notify_en <= NOTIFY_RESET;
            r_win_limit <= window_limit(WINDOW_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW: r_win_limit <= window_limit(i_cfg_data);
                CFG_NOTIFY: r_notify_en <= i_cfg_data[0];
                default:    r_notify_en <= r_notify_en;
            endcase
        end
    end

    // Input stage
    logic        r_in_valid;
    logic [31:0] r_time_ms;
    logic        r_pir_level;
    logic        r_out_valid;
    t_result     r_out;
    logic        advance;
    logic        take_in;
    t_result     core_res;

    // Advance the item into the result register when that register is free or draining.
    assign advance = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;
    assign take_in = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload needs no reset; capture on every input transfer.
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_time_ms   <= i_item.time_ms;
            r_pir_level <= i_item.pir_level;
        end
    end

    pirq_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_time_ms   (r_time_ms),
        .i_pir_level (r_pir_level),
        .i_win_limit (r_win_limit),
        .i_notify_en (r_notify_en),
        .o_result    (core_res)
    );

    // Result register: drop valid once taken unless a new item lands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.pir_state       = r_out.pir_state;
    assign o_result.sampled         = r_out.sampled;
    assign o_result.notify_valid    = r_out.notify_valid;
    assign o_result.notify_level    = r_out.notify_level;
    assign o_result.presence_count  = r_out.presence_count;
    assign o_result.burst_restarted = r_out.burst_restarted;

    // A start notification only comes with a sampled high.
    a_notify_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.notify_level |->
            o_result.notify_valid && o_result.sampled && o_result.pir_state)
        else $error("notify_level without a qualified detection");

    // A new burst always begins at count one with motion high.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.burst_restarted |->
            o_result.presence_count == 16'd1 && o_result.pir_state && o_result.sampled)
        else $error("burst restart with wrong count or state");

    // Input back-pressure only while a full pipe waits on the result side.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> r_in_valid && r_out_valid && !o_result.ready)
        else $error("input stalled without a downstream stall");

    // An advanced item always shows up as a valid result next cycle.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced item lost");

endmodule
